/* design/b32e_pkg.sv */
// ----------------------------------------------------------------------------
// b32e_pkg
// Shared types, constants and the digit alphabet of the base32 byte stream
// encoder.
// ----------------------------------------------------------------------------
package b32e_pkg;

	// field widths
	localparam int BYTE_W  = 8;
	localparam int CODE_W  = 7;
	localparam int DIGIT_W = 5;
	localparam int RES_W   = 4;   // up to four leftover bits
	localparam int RCNT_W  = 3;   // leftover bit count 0..4
	localparam int WORD_W  = 15;  // three digits, left aligned
	localparam int NDIG_W  = 2;   // one to three digits per job

	// default depth of the job queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// one classified byte: bits left aligned, digit count, end of message
	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [NDIG_W-1:0] ndig;
		logic              fin;
	} job_t;

	// queue handshake seen by the back end
	typedef struct packed {
		logic valid;
		job_t job;
	} queue_head_t;

	// lowercase crockford alphabet as ascii codes
	localparam logic [CODE_W-1:0] ALPHABET [32] = '{
		7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
		7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66,
		7'h67, 7'h68, 7'h6a, 7'h6b, 7'h6d, 7'h6e, 7'h70, 7'h71,
		7'h72, 7'h73, 7'h74, 7'h76, 7'h77, 7'h78, 7'h79, 7'h7a
	};

	function automatic logic [CODE_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] v);
		return ALPHABET[v];
	endfunction

endpackage

/* design/b32e_byte_if.sv */
// ----------------------------------------------------------------------------
// b32e_byte_if
// Valid/ready channel carrying one message byte and its end-of-message flag.
// ----------------------------------------------------------------------------
interface b32e_byte_if;
	logic                         valid;
	logic                         ready;
	logic [b32e_pkg::BYTE_W-1:0]  data_byte;
	logic                         final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

/* design/b32e_digit_if.sv */
// ----------------------------------------------------------------------------
// b32e_digit_if
// Valid/ready channel carrying one ascii base32 digit and its last flag.
// ----------------------------------------------------------------------------
interface b32e_digit_if;
	logic                         valid;
	logic                         ready;
	logic [b32e_pkg::CODE_W-1:0]  digit_code;
	logic                         last_digit;

	modport source (output valid, output digit_code, output last_digit, input ready);
	modport sink   (input valid, input digit_code, input last_digit, output ready);
endinterface

/* design/b32e_front.sv */
// ----------------------------------------------------------------------------
// b32e_front
// Accepts bytes, merges them with the leftover bits and classifies each into
// a job: left aligned bit word plus the number of digits it yields.
// ----------------------------------------------------------------------------
module b32e_front (
	input  logic             clk,
	input  logic             arst_n,
	b32e_byte_if.sink        bytes,
	input  logic             queue_full,
	output logic             push,
	output b32e_pkg::job_t   job
);

	logic [b32e_pkg::RES_W-1:0]  residue_q;
	logic [b32e_pkg::RCNT_W-1:0] rcnt_q;

	logic [11:0]                 acc;
	logic [3:0]                  nbits;
	logic [2:0]                  lshift;
	logic [b32e_pkg::RCNT_W-1:0] rem;
	logic [b32e_pkg::NDIG_W-1:0] nfloor;
	logic [b32e_pkg::NDIG_W-1:0] nceil;
	logic [b32e_pkg::RES_W-1:0]  rem_mask;

	assign bytes.ready = !queue_full;
	assign push        = bytes.valid && bytes.ready;

	// merge leftover bits above the new byte
	always_comb begin
		acc    = {residue_q, bytes.data_byte};
		nbits  = 4'd8 + {1'b0, rcnt_q};
		lshift = 3'd4 - rcnt_q;
	end

	// digit counts and leftover size per total bit count
	always_comb begin
		unique case (nbits)
			4'd8:    begin nfloor = 2'd1; nceil = 2'd2; rem = 3'd3; end
			4'd9:    begin nfloor = 2'd1; nceil = 2'd2; rem = 3'd4; end
			4'd10:   begin nfloor = 2'd2; nceil = 2'd2; rem = 3'd0; end
			4'd11:   begin nfloor = 2'd2; nceil = 2'd3; rem = 3'd1; end
			default: begin nfloor = 2'd2; nceil = 2'd3; rem = 3'd2; end
		endcase
		rem_mask = b32e_pkg::RES_W'((5'd1 << rem) - 5'd1);
	end

	// job for the queue
	always_comb begin
		job.word = b32e_pkg::WORD_W'({acc, 3'b000} << lshift);
		job.ndig = bytes.final_byte ? nceil : nfloor;
		job.fin  = bytes.final_byte;
	end

	// leftover state, cleared at end of message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			residue_q <= '0;
			rcnt_q    <= '0;
		end else if (push) begin
			if (bytes.final_byte) begin
				residue_q <= '0;
				rcnt_q    <= '0;
			end else begin
				residue_q <= acc[b32e_pkg::RES_W-1:0] & rem_mask;
				rcnt_q    <= rem;
			end
		end
	end

endmodule

/* design/b32e_queue.sv */
// ----------------------------------------------------------------------------
// b32e_queue
// Short first-in first-out queue of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module b32e_queue #(
	parameter int DEPTH = b32e_pkg::QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  b32e_pkg::job_t        push_job,
	input  logic                  pop,
	output logic                  full,
	output b32e_pkg::queue_head_t head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	b32e_pkg::job_t entry_q [DEPTH];
	logic [AW-1:0]  wptr_q;
	logic [AW-1:0]  rptr_q;
	logic [CW-1:0]  count_q;

	logic do_push;
	logic do_pop;

	assign full       = (count_q == FULL_CNT);
	assign head.valid = (count_q != '0);
	assign head.job   = entry_q[rptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head.valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == LAST_IDX) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == LAST_IDX) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* design/b32e_back.sv */
// ----------------------------------------------------------------------------
// b32e_back
// Walks the digits of the job at the queue head, one per cycle unless the
// digit output stalls, and drives the registered digit output.
// ----------------------------------------------------------------------------
module b32e_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  b32e_pkg::queue_head_t head,
	output logic                  pop,
	b32e_digit_if.source          digits
);

	logic [b32e_pkg::NDIG_W-1:0]  idx_q;
	logic                         ovalid_q;
	logic [b32e_pkg::CODE_W-1:0]  code_q;
	logic                         last_q;

	logic                         advance;
	logic                         last_in_job;
	logic [b32e_pkg::DIGIT_W-1:0] digit;

	assign digits.valid      = ovalid_q;
	assign digits.digit_code = code_q;
	assign digits.last_digit = last_q;

	assign advance     = head.valid && (!ovalid_q || digits.ready);
	assign last_in_job = (idx_q == head.job.ndig - 1'b1);
	assign pop         = advance && last_in_job;

	// pick the five bits of the current digit
	always_comb begin
		case (idx_q)
			2'd0:    digit = head.job.word[14:10];
			2'd1:    digit = head.job.word[9:5];
			default: digit = head.job.word[4:0];
		endcase
	end

	// digit index within the job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (advance) begin
			idx_q <= last_in_job ? '0 : idx_q + 1'b1;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (advance) begin
			ovalid_q <= 1'b1;
		end else if (digits.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			code_q <= b32e_pkg::digit_ascii(digit);
			last_q <= head.job.fin && last_in_job;
		end
	end

endmodule

/* design/base32_byte_stream_encoder_top.sv */
// ----------------------------------------------------------------------------
// base32_byte_stream_encoder_top
// Unpadded lowercase crockford base32 encoder for a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   bytes  : valid/ready sink, one message byte per request, final_byte set
//            on the last byte of the message.
//   digits : valid/ready source, one ascii digit per request, last_digit set
//            on the closing digit of the message.
//   Each byte yields one or two digits, up to three on a final byte; the
//   trailing bits of a final byte are zero padded into one closing digit.
//   The first digit of a byte passes the job queue, then the output register.
//   The back end emits one digit per cycle while the digit side is ready,
//   and a long message yields 8/5 digits per byte on average.
//   The front end takes a byte every cycle while the job queue has room;
//   the queue of QUEUE_DEPTH jobs plus the output register absorb a stall
//   on the digit side, and bytes.ready falls once the queue is full.
//   Reset clears the leftover bits, the queue and the output valid flag;
//   the block accepts bytes in the first cycle after reset.
// ----------------------------------------------------------------------------
module base32_byte_stream_encoder_top #(
	parameter int QUEUE_DEPTH = b32e_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	b32e_byte_if.sink    bytes,
	b32e_digit_if.source digits
);

	logic                  push;
	logic                  pop;
	logic                  queue_full;
	b32e_pkg::job_t        job;
	b32e_pkg::queue_head_t head;

	// byte intake and classification
	b32e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.bytes      (bytes),
		.queue_full (queue_full),
		.push       (push),
		.job        (job)
	);

	// job queue
	b32e_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (job),
		.pop      (pop),
		.full     (queue_full),
		.head     (head)
	);

	// digit emission
	b32e_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.digits (digits)
	);

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the base32 byte stream encoder. Messages of random bytes go in
// over the byte channel, one byte per request, with the end-of-message flag on
// the last byte. A scoreboard predicts the lowercase crockford digits that
// each byte should give and checks every digit that leaves the block, in
// order. Both channels idle and stall at random, with one calm stretch.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int LIMIT_CYCLES = 200000;
	localparam int GAP_PCT      = 26;
	localparam int RANDOM_BYTES = 205;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [b32e_pkg::CODE_W-1:0] code;
		logic                        last;
	} digit_t;

	// predicts the digits of each byte and checks them in order
	class digit_tracker;
		string                      alphabet = "0123456789abcdefghjkmnpqrstvwxyz";
		logic [b32e_pkg::RES_W-1:0] carry_bits;
		int                         carry_count;
		digit_t                     pending_digits[$];
		int                         bad_digits;

		function new();
			carry_bits  = '0;
			carry_count = 0;
			bad_digits  = 0;
		endfunction

		function void push_digit(logic [b32e_pkg::DIGIT_W-1:0] v, logic last);
			digit_t d;
			byte    ch;
			ch     = alphabet[v];
			d.code = ch[b32e_pkg::CODE_W-1:0];
			d.last = last;
			pending_digits.push_back(d);
		endfunction

		// accepted byte: emit every full group of five bits, msb first
		function void note_byte(logic [b32e_pkg::BYTE_W-1:0] data, logic fin);
			logic [11:0] acc;
			logic [11:0] keep_mask;
			int          nbits;
			acc   = {(carry_bits & b32e_pkg::RES_W'((1 << carry_count) - 1)), data};
			nbits = carry_count + b32e_pkg::BYTE_W;
			while (nbits >= b32e_pkg::DIGIT_W) begin
				nbits -= b32e_pkg::DIGIT_W;
				push_digit(b32e_pkg::DIGIT_W'(acc >> nbits), fin && nbits == 0);
			end
			keep_mask = 12'((1 << nbits) - 1);
			acc &= keep_mask;
			if (fin) begin
				// closing digit padded with zeros on the right
				if (nbits > 0)
					push_digit(b32e_pkg::DIGIT_W'(acc << (b32e_pkg::DIGIT_W - nbits)),
						1'b1);
				carry_bits  = '0;
				carry_count = 0;
			end else begin
				carry_bits  = b32e_pkg::RES_W'(acc);
				carry_count = nbits;
			end
		endfunction

		function void report(string msg);
			bad_digits++;
			if (bad_digits <= 10)
				$display("mismatch: %s", msg);
		endfunction

		function void check_digit(logic [b32e_pkg::CODE_W-1:0] code, logic last);
			digit_t want;
			if (pending_digits.size() == 0) begin
				report($sformatf("unexpected digit code 0x%02h last %0b", code, last));
				return;
			end
			want = pending_digits.pop_front();
			if (code !== want.code)
				report($sformatf("digit_code expected 0x%02h got 0x%02h", want.code, code));
			if (last !== want.last)
				report($sformatf("last_digit expected %0b got %0b (code 0x%02h)",
					want.last, last, want.code));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic calm;
	int   cycles;

	b32e_byte_if  byte_ch();
	b32e_digit_if digit_ch();

	digit_tracker tracker;

	base32_byte_stream_encoder_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (byte_ch),
		.digits (digit_ch)
	);

	// clock
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	// digit side stalls
	always @(posedge clk) begin
		digit_ch.ready <= calm || ($urandom_range(0, 99) >= GAP_PCT);
	end

	// digit side monitor
	always @(posedge clk) begin
		if (arst_n && digit_ch.valid && digit_ch.ready)
			tracker.check_digit(digit_ch.digit_code, digit_ch.last_digit);
	end

	// one byte request, with an optional random gap in front
	task automatic send_byte(input logic [b32e_pkg::BYTE_W-1:0] data, input logic fin);
		while (!calm && $urandom_range(0, 99) < GAP_PCT) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid      <= 1'b1;
		byte_ch.data_byte  <= data;
		byte_ch.final_byte <= fin;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		tracker.note_byte(data, fin);
	endtask

	// random message of a given length, flagged on its last byte
	task automatic send_message(input int len);
		for (int i = 0; i < len; i++)
			send_byte(b32e_pkg::BYTE_W'($urandom), i == len - 1);
	endtask

	initial begin
		int sent;
		int len;
		tracker             = new();
		cycles              = 0;
		calm                = 1'b0;
		arst_n              = 1'b0;
		byte_ch.valid       = 1'b0;
		byte_ch.data_byte   = '0;
		byte_ch.final_byte  = 1'b0;
		digit_ch.ready      = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-byte messages at the extremes: zero padded closing digit
		send_byte(8'h00, 1'b1);
		send_byte(8'hff, 1'b1);
		// five bytes end on a digit boundary, so no closing digit
		send_byte(8'hff, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'haa, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'h81, 1'b1);
		// two, three and four bytes leave one, four and two bits over
		send_byte(8'h7f, 1'b0);
		send_byte(8'h80, 1'b1);
		send_byte(8'h01, 1'b0);
		send_byte(8'hfe, 1'b0);
		send_byte(8'hc3, 1'b1);
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b1);
		// all-zero five byte message, then a single byte after it
		for (int i = 0; i < 5; i++)
			send_byte(8'h00, i == 4);
		send_byte(8'h3c, 1'b1);

		// random messages, mostly short, with a calm stretch in the middle
		sent = 0;
		while (sent < RANDOM_BYTES) begin
			calm = (sent >= 90 && sent < 150);
			len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30)
			                                   : $urandom_range(1, 12);
			send_message(len);
			sent += len;
		end
		byte_ch.valid <= 1'b0;
		calm = 1'b1;

		// drain
		while (tracker.pending_digits.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (tracker.bad_digits == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
